// File: rtl/swm_pkg.sv
// Shared constants and types for the sliding window maximum block.
// Used by swm_cell, swm_ctrl and sliding_window_max; no dependencies.
package swm_pkg;

    localparam int WINDOW_MAX = 64;
    localparam int SAMPLE_W   = 16;
    localparam int POS_W      = $clog2(2 * WINDOW_MAX);
    localparam int CNT_W      = $clog2(WINDOW_MAX + 1);
    localparam int CFG_W      = 7;

    // One deque entry held by a cell
    typedef struct packed {
        logic                       valid;
        logic signed [SAMPLE_W-1:0] value;
        logic [POS_W-1:0]           pos;
    } t_cell;

    // Per-cycle commands from the controller to every cell
    typedef struct packed {
        logic load;   // an item is accepted this cycle
        logic shift;  // drop the front entry, every cell takes its right neighbor
        logic clear;  // end of sequence, empty the chain
    } t_cell_ctl;

endpackage

// File: rtl/swm_cell.sv
// One cell of the candidate chain: holds one deque entry.
// Depends on swm_pkg for the entry and command types.
module swm_cell (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  swm_pkg::t_cell_ctl                  i_ctl,
    input  logic signed [swm_pkg::SAMPLE_W-1:0] i_sample,
    input  logic [swm_pkg::POS_W-1:0]           i_pos,
    input  swm_pkg::t_cell                      i_next,
    input  logic                                i_prev_keep,
    output swm_pkg::t_cell                      o_cell,
    output logic                                o_keep
);
    import swm_pkg::*;

    t_cell r_cell;
    t_cell n_cell;
    t_cell w_src;

    // Pick own entry or the neighbor's when the front is dropped
    assign w_src  = i_ctl.shift ? i_next : r_cell;
    // Keep the entry unless the new sample is strictly larger
    assign o_keep = w_src.valid && !($signed(w_src.value) < $signed(i_sample));

    // Next: clear, keep, take the sample after the last kept entry, or drop
    always_comb begin
        n_cell = r_cell;
        if (i_ctl.clear) begin
            n_cell.valid = 1'b0;
        end else if (i_ctl.load) begin
            if (o_keep) begin
                n_cell = w_src;
            end else if (i_prev_keep) begin
                n_cell.valid = 1'b1;
                n_cell.value = i_sample;
                n_cell.pos   = i_pos;
            end else begin
                n_cell.valid = 1'b0;
            end
        end else if (i_ctl.shift) begin
            n_cell = w_src;
        end
    end

    // Register the entry; only the valid bit is reset
    always_ff @(posedge i_clk) begin
        r_cell.value <= n_cell.value;
        r_cell.pos   <= n_cell.pos;
        if (!i_rst_n) begin
            r_cell.valid <= 1'b0;
        end else begin
            r_cell.valid <= n_cell.valid;
        end
    end

    assign o_cell = r_cell;

endmodule

// File: rtl/swm_ctrl.sv
// Controller: window register, counters, front expiry, handshakes, result register.
// Depends on swm_pkg; drives the command struct shared by all cells.
module swm_ctrl (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [swm_pkg::CFG_W-1:0]           i_cfg_wdata,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [swm_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                                i_end_of_sequence,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [swm_pkg::SAMPLE_W-1:0] o_window_max,
    output logic                                o_last_result,
    input  swm_pkg::t_cell                      i_front,
    input  swm_pkg::t_cell                      i_second,
    input  logic                                i_front_keep,
    output swm_pkg::t_cell_ctl                  o_ctl,
    output logic [swm_pkg::POS_W-1:0]           o_pos
);
    import swm_pkg::*;

    logic [CFG_W-1:0]           r_win;
    logic [CFG_W-1:0]           w_k;
    logic [POS_W-1:0]           r_pos;
    logic [CNT_W-1:0]           r_seen;
    logic [CNT_W-1:0]           w_seen_inc;
    logic [POS_W-1:0]           w_age0;
    logic [POS_W-1:0]           w_age1;
    logic                       w_exp0;
    logic                       w_exp1;
    logic                       w_purge;
    logic                       w_accept;
    logic                       w_produce;
    logic signed [SAMPLE_W-1:0] w_front_val;
    logic                       r_out_valid;
    logic signed [SAMPLE_W-1:0] r_out_max;
    logic                       r_out_last;

    // Window register; the user must write it only while idle, the block itself does not enforce this
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= CFG_W'(1);
        end else if (i_cfg_we) begin
            r_win <= i_cfg_wdata;
        end
    end

    // Clamp the window to 1..WINDOW_MAX
    always_comb begin
        if (r_win == '0) begin
            w_k = CFG_W'(1);
        end else if (r_win > CFG_W'(WINDOW_MAX)) begin
            w_k = CFG_W'(WINDOW_MAX);
        end else begin
            w_k = r_win;
        end
    end

    // Ages of the two front entries relative to the incoming position
    assign w_age0 = r_pos - i_front.pos;
    assign w_age1 = r_pos - i_second.pos;
    assign w_exp0 = i_front.valid && (CFG_W'(w_age0) >= w_k);
    assign w_exp1 = i_second.valid && (CFG_W'(w_age1) >= w_k);

    // More than one stale entry ahead of a waiting item: drop one per cycle, hold input
    assign w_purge  = i_valid && w_exp0 && w_exp1;
    assign o_ready  = !w_purge && (!r_out_valid || i_ready);
    assign w_accept = i_valid && o_ready;

    assign o_ctl.load  = w_accept;
    assign o_ctl.shift = w_purge || (w_accept && w_exp0);
    assign o_ctl.clear = w_accept && i_end_of_sequence;
    assign o_pos       = r_pos;

    // Sample count after this item, saturating at the window limit
    assign w_seen_inc = (r_seen < CNT_W'(WINDOW_MAX)) ? r_seen + CNT_W'(1) : r_seen;
    assign w_produce  = CFG_W'(w_seen_inc) >= w_k;

    // Front value after this item: the new sample, the second entry or the front entry
    assign w_front_val = i_front_keep ? (w_exp0 ? i_second.value : i_front.value) : i_sample;

    // Advance or clear the sequence counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_seen <= '0;
        end else if (w_accept) begin
            if (i_end_of_sequence) begin
                r_pos  <= '0;
                r_seen <= '0;
            end else begin
                r_pos  <= r_pos + POS_W'(1);
                r_seen <= w_seen_inc;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept && w_produce) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_produce) begin
            r_out_max  <= w_front_val;
            r_out_last <= i_end_of_sequence;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_window_max  = r_out_max;
    assign o_last_result = r_out_last;

`ifndef SYNTHESIS
    a_seen_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen <= CNT_W'(WINDOW_MAX))
        else $error("sample count beyond window limit");

    a_eos_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_end_of_sequence) |=> (r_pos == '0 && r_seen == '0))
        else $error("counters not cleared after last item");

    a_no_load_in_purge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_purge |-> !o_ctl.load)
        else $error("item taken while stale entries remain");
`endif

endmodule

// File: rtl/sliding_window_max.sv
// Sliding window maximum over a signed sample stream, kept as a monotonic deque.
// Each result is registered into the output register in the cycle after its item is taken.
// Items: one per cycle while the output is not stalled; after a window shrink, input is
// held while stale front entries beyond the first are dropped by the one-step shift.
// Reset: synchronous active-low; clears entry valid bits, counters, output valid, window to 1.
// Depends on swm_pkg, swm_cell and swm_ctrl.
module sliding_window_max (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [swm_pkg::CFG_W-1:0]           i_cfg_wdata,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [swm_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                                i_end_of_sequence,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [swm_pkg::SAMPLE_W-1:0] o_window_max,
    output logic                                o_last_result
);
    import swm_pkg::*;

    t_cell                 w_cell [0:WINDOW_MAX];
    logic [WINDOW_MAX-1:0] w_keep;
    logic [WINDOW_MAX-1:0] w_valid;
    t_cell_ctl             w_ctl;
    logic [POS_W-1:0]      w_pos;

    // Nothing enters from beyond the last cell
    assign w_cell[WINDOW_MAX] = '0;

    swm_ctrl u_ctrl (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_sample          (i_sample),
        .i_end_of_sequence (i_end_of_sequence),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_window_max      (o_window_max),
        .o_last_result     (o_last_result),
        .i_front           (w_cell[0]),
        .i_second          (w_cell[1]),
        .i_front_keep      (w_keep[0]),
        .o_ctl             (w_ctl),
        .o_pos             (w_pos)
    );

    // Candidate chain, front entry in cell 0
    for (genvar gi = 0; gi < WINDOW_MAX; gi++) begin : g_cell
        logic w_prev_keep;
        if (gi == 0) begin : g_first
            assign w_prev_keep = 1'b1;
        end else begin : g_rest
            assign w_prev_keep = w_keep[gi-1];
        end

        swm_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (w_ctl),
            .i_sample    (i_sample),
            .i_pos       (w_pos),
            .i_next      (w_cell[gi+1]),
            .i_prev_keep (w_prev_keep),
            .o_cell      (w_cell[gi]),
            .o_keep      (w_keep[gi])
        );

        assign w_valid[gi] = w_cell[gi].valid;
    end

`ifndef SYNTHESIS
    a_packed_front: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_valid & (w_valid + WINDOW_MAX'(1))) == '0)
        else $error("valid entries not packed toward the front");

    a_front_after_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && !i_end_of_sequence) |=> w_cell[0].valid)
        else $error("front entry missing after an item");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=>
            (o_valid && $stable(o_window_max) && $stable(o_last_result)))
        else $error("waiting result dropped or changed");
`endif

endmodule
